// ----- hdl/occ_pkg.sv -----
// occ_pkg: shared types and constants of the occupancy cell colour map
// holds the cell class codes, register indexes, stage advance and config structs
// no dependencies
package occ_pkg;

   // field and datapath widths
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int THR_W       = 7;
   localparam int SPAN_W      = 7;
   localparam int PROD_W      = CHAN_W + SPAN_W;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;
   localparam int NUM_STAGES  = 5;

   // cells above this value start the blend
   localparam logic [THR_W-1:0] BLEND_FLOOR = 7'd20;

   // register reset values
   localparam logic [THR_W-1:0]   THR_RESET   = 7'd65;
   localparam logic [COLOR_W-1:0] UNK_RESET   = 24'h808080;
   localparam logic [COLOR_W-1:0] FREE_RESET  = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] OCC_RESET   = 24'h000000;

   // pixel class codes
   typedef enum logic [1:0] {
      CLASS_FREE    = 2'd0,
      CLASS_BLEND   = 2'd1,
      CLASS_OCC     = 2'd2,
      CLASS_UNKNOWN = 2'd3
   } cls_type;

   // register indexes, byte address is 4 times the index
   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_UNKNOWN   = 2'd1,
      REG_FREE      = 2'd2,
      REG_OCCUPIED  = 2'd3
   } reg_index_type;

   // per-stage load strobes handed to the channel lanes
   typedef struct packed {
      logic st2;
      logic st3;
      logic st4;
      logic st5;
   } adv_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [COLOR_W-1:0] unknown_color;
      logic [COLOR_W-1:0] free_color;
      logic [COLOR_W-1:0] occupied_color;
      logic [SPAN_W-1:0]  span;
      logic [RECIP_W-1:0] recip;
   } cfg_type;

endpackage

// ----- hdl/occ_req_if.sv -----
// occ_req_if: input channel carrying one occupancy cell per transfer
// depends on nothing
interface occ_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] cell_value;
   logic              last_cell;

   modport source (output valid, cell_value, last_cell, input ready);
   modport sink   (input valid, cell_value, last_cell, output ready);
endinterface

// ----- hdl/occ_rsp_if.sv -----
// occ_rsp_if: result channel carrying one RGB888 pixel per transfer
// depends on nothing
interface occ_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [1:0] cell_class;
   logic       last_pixel;

   modport source (output valid, red, green, blue, cell_class, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, cell_class, last_pixel, output ready);
endinterface

// ----- hdl/occ_csr.sv -----
// occ_csr: APB-style register file of the colour map
// holds threshold and colours, and the blend span with its reciprocal; uses occ_pkg
module occ_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [occ_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [occ_pkg::DATA_W-1:0] csr_pwdata,
   output logic [occ_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output occ_pkg::cfg_type           cfg
);

   localparam int LUT_DEPTH = 2 ** occ_pkg::THR_W;

   logic [occ_pkg::THR_W-1:0]   thr_ff,   thr_in;
   logic [occ_pkg::COLOR_W-1:0] unk_ff,   unk_in;
   logic [occ_pkg::COLOR_W-1:0] free_ff,  free_in;
   logic [occ_pkg::COLOR_W-1:0] occ_ff,   occ_in;
   logic [occ_pkg::SPAN_W-1:0]  span_ff,  span_in;
   logic [occ_pkg::RECIP_W-1:0] recip_ff, recip_in;
   logic [occ_pkg::RECIP_W-1:0] recip_lut [LUT_DEPTH];
   logic                        wr_en;
   occ_pkg::reg_index_type      reg_idx;
   logic [occ_pkg::THR_W-1:0]   wr_thr;

   // reciprocal table: floor(2^24 / (threshold - 20)), divisor taken as one where no blend exists
   for (genvar gi = 0; gi < LUT_DEPTH; gi++) begin : g_recip
      localparam int SPAN  = (gi > int'(occ_pkg::BLEND_FLOOR)) ?
                             gi - int'(occ_pkg::BLEND_FLOOR) : 1;
      localparam logic [occ_pkg::RECIP_W-1:0] RECIP =
         occ_pkg::RECIP_W'((64'd1 << occ_pkg::RECIP_SHIFT) / SPAN);
      assign recip_lut[gi] = RECIP;
   end

   // write decode
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = occ_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_thr  = csr_pwdata[occ_pkg::THR_W-1:0];

   // register next values
   always_comb begin
      thr_in   = thr_ff;
      unk_in   = unk_ff;
      free_in  = free_ff;
      occ_in   = occ_ff;
      span_in  = span_ff;
      recip_in = recip_ff;
      if (wr_en) begin
         case (reg_idx)
            occ_pkg::REG_THRESHOLD: begin
               thr_in   = wr_thr;
               span_in  = wr_thr - occ_pkg::BLEND_FLOOR;
               recip_in = recip_lut[wr_thr];
            end
            occ_pkg::REG_UNKNOWN:  unk_in  = csr_pwdata[occ_pkg::COLOR_W-1:0];
            occ_pkg::REG_FREE:     free_in = csr_pwdata[occ_pkg::COLOR_W-1:0];
            occ_pkg::REG_OCCUPIED: occ_in  = csr_pwdata[occ_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= occ_pkg::THR_RESET;
         unk_ff   <= occ_pkg::UNK_RESET;
         free_ff  <= occ_pkg::FREE_RESET;
         occ_ff   <= occ_pkg::OCC_RESET;
         span_ff  <= occ_pkg::THR_RESET - occ_pkg::BLEND_FLOOR;
         recip_ff <= recip_lut[occ_pkg::THR_RESET];
      end else begin
         thr_ff   <= thr_in;
         unk_ff   <= unk_in;
         free_ff  <= free_in;
         occ_ff   <= occ_in;
         span_ff  <= span_in;
         recip_ff <= recip_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         occ_pkg::REG_THRESHOLD: csr_prdata = {25'd0, thr_ff};
         occ_pkg::REG_UNKNOWN:   csr_prdata = {8'd0, unk_ff};
         occ_pkg::REG_FREE:      csr_prdata = {8'd0, free_ff};
         occ_pkg::REG_OCCUPIED:  csr_prdata = {8'd0, occ_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.threshold      = thr_ff;
   assign cfg.unknown_color  = unk_ff;
   assign cfg.free_color     = free_ff;
   assign cfg.occupied_color = occ_ff;
   assign cfg.span           = span_ff;
   assign cfg.recip          = recip_ff;

endmodule

// ----- hdl/occ_lane.sv -----
// occ_lane: one colour channel of the blend pipeline, stages two to five
// scale, reciprocal multiply, quotient correction, final add and class select; uses occ_pkg
module occ_lane (
   input  logic                       clock,
   input  occ_pkg::adv_type           adv,
   input  logic [occ_pkg::SPAN_W-1:0] span,
   input  logic [occ_pkg::RECIP_W-1:0] recip,
   input  logic [occ_pkg::SPAN_W-1:0] d1,
   input  occ_pkg::cls_type           cls4,
   input  logic [occ_pkg::CHAN_W-1:0] free_chan,
   input  logic [occ_pkg::CHAN_W-1:0] occ_chan,
   input  logic [occ_pkg::CHAN_W-1:0] unk_chan,
   output logic [occ_pkg::CHAN_W-1:0] chan_out
);

   localparam int MUL_W = occ_pkg::PROD_W + occ_pkg::RECIP_W;

   logic                        neg;
   logic [occ_pkg::CHAN_W-1:0]  mag;
   logic [occ_pkg::PROD_W-1:0]  p2_ff,   p2_in;
   logic                        neg2_ff;
   logic [MUL_W-1:0]            prod3;
   logic [occ_pkg::CHAN_W-1:0]  q3_ff,   q3_in;
   logic [occ_pkg::PROD_W-1:0]  p3_ff;
   logic                        neg3_ff;
   logic [occ_pkg::PROD_W-1:0]  qs4;
   logic [occ_pkg::PROD_W-1:0]  rem4;
   logic [occ_pkg::CHAN_W-1:0]  q4_ff,   q4_in;
   logic                        neg4_ff;
   logic [occ_pkg::CHAN_W-1:0]  blend4;
   logic [occ_pkg::CHAN_W-1:0]  chan5_ff, chan5_in;

   // sign and magnitude of occupied minus free
   assign neg = occ_chan < free_chan;
   assign mag = neg ? free_chan - occ_chan : occ_chan - free_chan;

   // stage 2: magnitude times distance above the floor
   assign p2_in = {{occ_pkg::SPAN_W{1'b0}}, mag} * {{occ_pkg::CHAN_W{1'b0}}, d1};

   // stage 3: quotient estimate, floor or one below the true quotient
   assign prod3 = {{occ_pkg::RECIP_W{1'b0}}, p2_ff} * {{occ_pkg::PROD_W{1'b0}}, recip};
   assign q3_in = prod3[occ_pkg::RECIP_SHIFT +: occ_pkg::CHAN_W];

   // stage 4: one correction step on the remainder
   assign qs4   = {{occ_pkg::SPAN_W{1'b0}}, q3_ff} * {{occ_pkg::CHAN_W{1'b0}}, span};
   assign rem4  = p3_ff - qs4;
   assign q4_in = (rem4 >= {{occ_pkg::CHAN_W{1'b0}}, span}) ? q3_ff + 8'd1 : q3_ff;

   // stage 5: step from the free colour and pick by class
   assign blend4 = neg4_ff ? free_chan - q4_ff : free_chan + q4_ff;

   always_comb begin
      case (cls4)
         occ_pkg::CLASS_FREE:    chan5_in = free_chan;
         occ_pkg::CLASS_BLEND:   chan5_in = blend4;
         occ_pkg::CLASS_OCC:     chan5_in = occ_chan;
         occ_pkg::CLASS_UNKNOWN: chan5_in = unk_chan;
         default:                chan5_in = free_chan;
      endcase
   end

   // stage registers, payload only
   always_ff @(posedge clock) begin
      if (adv.st2) begin
         p2_ff   <= p2_in;
         neg2_ff <= neg;
      end
      if (adv.st3) begin
         q3_ff   <= q3_in;
         p3_ff   <= p2_ff;
         neg3_ff <= neg2_ff;
      end
      if (adv.st4) begin
         q4_ff   <= q4_in;
         neg4_ff <= neg3_ff;
      end
      if (adv.st5) begin
         chan5_ff <= chan5_in;
      end
   end

   assign chan_out = chan5_ff;

endmodule

// ----- hdl/occupancy_cell_colormap.sv -----
// occupancy_cell_colormap: top level of the occupancy cell colour map
// five-stage pipeline with valid/ready flow; uses occ_pkg, occ_req_if, occ_rsp_if,
// occ_csr and occ_lane
//
// Usage:
//   req_bus carries one signed occupancy cell and a last-cell mark per transfer.
//   rsp_bus carries one RGB888 pixel, its class and the last-pixel mark per transfer,
//   in the same order as the cells.
//   The csr_ port holds the occupied threshold and the unknown, free and occupied
//   colours; write it only while no cell is in flight.
// Throughput: one cell per cycle while rsp_bus.ready stays high; five register
//   stages with a valid bit each, the blend divide being a reciprocal multiply and a
//   remainder correction.
// Reset: all stages empty, registers back to threshold 65, unknown 0x808080,
//   free 0xFFFFFF, occupied 0x000000.
// Stall: when rsp_bus.ready is low the pipeline holds in place and bubbles close up;
//   req_bus.ready drops once all five stages hold a cell.
module occupancy_cell_colormap (
   input  logic                       clock,
   input  logic                       reset,
   occ_req_if.sink                    req_bus,
   occ_rsp_if.source                  rsp_bus,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [occ_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [occ_pkg::DATA_W-1:0] csr_pwdata,
   output logic [occ_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int NS = occ_pkg::NUM_STAGES;

   occ_pkg::cfg_type            cfg;
   occ_pkg::adv_type            adv;
   logic [NS-1:0]               valid_ff, valid_in;
   logic [NS-1:0]               stage_ready;
   logic [NS-1:0]               up_valid;
   logic [NS-1:0]               load;
   occ_pkg::cls_type            cls_ff  [NS];
   logic                        last_ff [NS];
   occ_pkg::cls_type            cls1_in;
   logic [occ_pkg::SPAN_W-1:0]  d1_ff, d1_in;
   logic [occ_pkg::THR_W-1:0]   cell_mag;

   // register file
   occ_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ready chain from the output back to the input
   always_comb begin
      stage_ready[NS-1] = !valid_ff[NS-1] || rsp_bus.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
   end

   // valid bits and load strobes
   always_comb begin
      up_valid[0] = req_bus.valid;
      for (int i = 1; i < NS; i++) begin
         up_valid[i] = valid_ff[i-1];
      end
      for (int i = 0; i < NS; i++) begin
         load[i]     = up_valid[i] && stage_ready[i];
         valid_in[i] = stage_ready[i] ? up_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign adv.st2 = load[1];
   assign adv.st3 = load[2];
   assign adv.st4 = load[3];
   assign adv.st5 = load[4];

   // stage 1: classify the cell
   assign cell_mag = req_bus.cell_value[occ_pkg::THR_W-1:0];
   assign d1_in    = cell_mag - occ_pkg::BLEND_FLOOR;

   always_comb begin
      if (req_bus.cell_value[7]) begin
         cls1_in = occ_pkg::CLASS_UNKNOWN;
      end else if (cell_mag >= cfg.threshold) begin
         cls1_in = occ_pkg::CLASS_OCC;
      end else if (cell_mag > occ_pkg::BLEND_FLOOR) begin
         cls1_in = occ_pkg::CLASS_BLEND;
      end else begin
         cls1_in = occ_pkg::CLASS_FREE;
      end
   end

   // class and frame mark travel with the data
   always_ff @(posedge clock) begin
      if (load[0]) begin
         cls_ff[0]  <= cls1_in;
         last_ff[0] <= req_bus.last_cell;
         d1_ff      <= d1_in;
      end
      for (int i = 1; i < NS; i++) begin
         if (load[i]) begin
            cls_ff[i]  <= cls_ff[i-1];
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   // one lane per colour channel
   occ_lane u_lane_red (
      .clock     (clock),
      .adv       (adv),
      .span      (cfg.span),
      .recip     (cfg.recip),
      .d1        (d1_ff),
      .cls4      (cls_ff[3]),
      .free_chan (cfg.free_color[23:16]),
      .occ_chan  (cfg.occupied_color[23:16]),
      .unk_chan  (cfg.unknown_color[23:16]),
      .chan_out  (rsp_bus.red)
   );

   occ_lane u_lane_green (
      .clock     (clock),
      .adv       (adv),
      .span      (cfg.span),
      .recip     (cfg.recip),
      .d1        (d1_ff),
      .cls4      (cls_ff[3]),
      .free_chan (cfg.free_color[15:8]),
      .occ_chan  (cfg.occupied_color[15:8]),
      .unk_chan  (cfg.unknown_color[15:8]),
      .chan_out  (rsp_bus.green)
   );

   occ_lane u_lane_blue (
      .clock     (clock),
      .adv       (adv),
      .span      (cfg.span),
      .recip     (cfg.recip),
      .d1        (d1_ff),
      .cls4      (cls_ff[3]),
      .free_chan (cfg.free_color[7:0]),
      .occ_chan  (cfg.occupied_color[7:0]),
      .unk_chan  (cfg.unknown_color[7:0]),
      .chan_out  (rsp_bus.blue)
   );

   // channel handshake and frame outputs
   assign req_bus.ready      = stage_ready[0];
   assign rsp_bus.valid      = valid_ff[NS-1];
   assign rsp_bus.cell_class = cls_ff[NS-1];
   assign rsp_bus.last_pixel = last_ff[NS-1];

`ifndef ASSERT_OFF
   // an accepted cell always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> valid_ff[0])
      else $error("accepted cell did not enter stage 1");

   // a held stage keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(valid_ff & ~stage_ready) & ~valid_ff) == '0))
      else $error("stalled stage lost its item");

   // unknown pixels carry the unknown colour
   a_unknown_color: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.cell_class == occ_pkg::CLASS_UNKNOWN |->
      {rsp_bus.red, rsp_bus.green, rsp_bus.blue} == cfg.unknown_color)
      else $error("unknown pixel colour mismatch");

   // a blended red channel lies between the free and occupied values
   a_blend_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.cell_class == occ_pkg::CLASS_BLEND |->
      ((cfg.free_color[23:16] <= cfg.occupied_color[23:16]) ?
         (rsp_bus.red >= cfg.free_color[23:16] &&
          rsp_bus.red <= cfg.occupied_color[23:16]) :
         (rsp_bus.red <= cfg.free_color[23:16] &&
          rsp_bus.red >= cfg.occupied_color[23:16])))
      else $error("blended red outside its endpoints");
`endif

endmodule
